/* src/afv_pkg.sv */
package afv_pkg;

  // Storage geometry
  localparam int FIFO_DEPTH = 4096;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Port widths fixed by the item format
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 7;
  localparam int CHAN_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int FILL_W   = 13;
  localparam int TALLY_W  = 32;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd5;

  localparam logic [VOL_W-1:0]  VOL_UNITY     = 7'd100;
  localparam logic [CHAN_W-1:0] CHAN_MAX      = 4'd8;
  localparam logic [CHAN_W-1:0] CHAN_RESET    = 4'd2;

  // Divide by 100: q = (m * DIV_RECIP) >> DIV_SHIFT, exact for m < 6.1e6
  localparam int               PROD_W    = 24;
  localparam int               MAG_W     = 22;
  localparam int               RECIP_W   = 23;
  localparam int               DIV_SHIFT = 29;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd5368710;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [VOL_W-1:0]    vol;
  } scale_req_t;

endpackage

/* src/audio_playback_fifo_with_volume.sv */
// Playback sample FIFO with per-channel volume. Each input transfer carries
// one operation: write a sample, read the oldest sample, or flush. Every item
// yields exactly one result transfer carrying the read sample (zero
// otherwise), accepted/underrun flags, the fill level after the item and the
// running count of stored samples. Items are handled one at a time: a new
// item is taken only once the previous one has committed, and its result is
// registered at commit. The sequencer runs the two-stage scaling multiplier
// (product, then divide by 100 through a reciprocal multiply) with the
// commit state behind it, and the sample RAM read, issued in the first of
// those states after the input transfer, fits inside the same
// window. A new item can be taken while the previous result still waits in
// the output register; the commit cycle stalls only if that register is
// still full. The sample RAM (FIFO_DEPTH x 16) needs no clearing: only
// entries written since the last flush are ever read. Configuration writes
// land at once and are expected only while the block is idle.
module audio_playback_fifo_with_volume (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [afv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afv_pkg::CFG_DATA_W-1:0]    cfg_data,
  // item channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [afv_pkg::OP_W-1:0]          operation,
  input  logic [afv_pkg::SAMPLE_W-1:0]      sample_in,
  input  logic                              last_of_block,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [afv_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                              accepted,
  output logic                              underrun,
  output logic [afv_pkg::FILL_W-1:0]        fill_level,
  output logic [afv_pkg::TALLY_W-1:0]       written_total
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic                         fmt16;
  logic [afv_pkg::CHAN_W-1:0]   chan_cnt;
  logic [afv_pkg::VOL_W-1:0]    vol_left;
  logic [afv_pkg::VOL_W-1:0]    vol_right;
  logic                         paused;
  logic                         active;

  // item held for the duration of its processing
  logic [afv_pkg::OP_W-1:0]     op;
  logic [afv_pkg::SAMPLE_W-1:0] sample;
  logic                         last;

  // FIFO state
  logic [afv_pkg::SAMPLE_W-1:0] mem [afv_pkg::FIFO_DEPTH];
  logic [afv_pkg::SAMPLE_W-1:0] rd_data;
  logic [afv_pkg::PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [afv_pkg::PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [afv_pkg::OCC_W-1:0]    occ, occ_next;
  logic [afv_pkg::PHASE_W-1:0]  phase, phase_next;
  logic [afv_pkg::TALLY_W-1:0]  tally, tally_next;

  // write path
  logic [afv_pkg::CHAN_W-1:0]   nch;
  logic [afv_pkg::PHASE_W-1:0]  ph;
  logic [afv_pkg::CHAN_W-1:0]   ph_inc;
  logic                         scale_en;
  afv_pkg::scale_req_t          scale_req;
  logic [afv_pkg::SAMPLE_W-1:0] scaled;
  logic [afv_pkg::SAMPLE_W-1:0] wr_value;
  logic                         mem_we;

  // result
  logic                         out_free;
  logic                         commit;
  logic [afv_pkg::SAMPLE_W-1:0] res_sample;
  logic                         res_acc;
  logic                         res_under;

  function automatic logic [afv_pkg::PTR_W-1:0] ptr_inc(input logic [afv_pkg::PTR_W-1:0] p);
    ptr_inc = (p == afv_pkg::PTR_W'(afv_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt16     <= 1'b1;
      chan_cnt  <= afv_pkg::CHAN_RESET;
      vol_left  <= afv_pkg::VOL_UNITY;
      vol_right <= afv_pkg::VOL_UNITY;
      paused    <= 1'b0;
      active    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        afv_pkg::REG_FORMAT:    fmt16     <= cfg_data[0];
        afv_pkg::REG_CHANNELS:  chan_cnt  <= cfg_data[afv_pkg::CHAN_W-1:0];
        afv_pkg::REG_VOL_LEFT:  vol_left  <= cfg_data;
        afv_pkg::REG_VOL_RIGHT: vol_right <= cfg_data;
        afv_pkg::REG_PAUSED:    paused    <= cfg_data[0];
        afv_pkg::REG_ACTIVE:    active    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == ST_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    state_next = ST_COMMIT;
      ST_COMMIT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // item capture on the input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op     <= operation;
      sample <= sample_in;
      last   <= last_of_block;
    end
  end

  // ---------------- channel phase and scaling ----------------
  always_comb begin
    if (chan_cnt == '0)                  nch = 4'd1;
    else if (chan_cnt > afv_pkg::CHAN_MAX) nch = afv_pkg::CHAN_MAX;
    else                                 nch = chan_cnt;
    // a stale phase at or past the channel count restarts at channel 0
    ph       = ({1'b0, phase} >= nch) ? '0 : phase;
    ph_inc   = {1'b0, ph} + 4'd1;
    scale_en = fmt16 &&
               ((vol_left != afv_pkg::VOL_UNITY) || (vol_right != afv_pkg::VOL_UNITY)) &&
               ((ph == 3'd0) || ((ph == 3'd1) && (nch > 4'd1)));
    scale_req.sample = sample;
    scale_req.vol    = (ph == 3'd0) ? vol_left : vol_right;
  end

  afv_scale u_scale (
    .clk    (clk),
    .req    (scale_req),
    .scaled (scaled)
  );

  // eight-bit format keeps the low byte only
  always_comb begin
    if (scale_en)   wr_value = scaled;
    else if (fmt16) wr_value = sample;
    else            wr_value = {8'h00, sample[7:0]};
  end

  // ---------------- commit ----------------
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    occ_next    = occ;
    phase_next  = phase;
    tally_next  = tally;
    res_sample  = '0;
    res_acc     = 1'b0;
    res_under   = 1'b0;
    mem_we      = 1'b0;
    case (op)
      afv_pkg::OP_WRITE: begin
        if (active && (occ < afv_pkg::OCC_W'(afv_pkg::FIFO_DEPTH))) begin
          mem_we      = commit;
          wr_ptr_next = ptr_inc(wr_ptr);
          occ_next    = occ + 1'b1;
          tally_next  = tally + 1'b1;
          res_acc     = 1'b1;
        end
        // phase moves on every write, stored or dropped
        if (last || (ph_inc >= nch)) phase_next = '0;
        else                         phase_next = ph_inc[afv_pkg::PHASE_W-1:0];
      end
      afv_pkg::OP_READ: begin
        if (paused || !active || (occ == '0)) begin
          res_under = 1'b1;
        end else begin
          res_sample  = rd_data;
          rd_ptr_next = ptr_inc(rd_ptr);
          occ_next    = occ - 1'b1;
          res_acc     = 1'b1;
        end
      end
      afv_pkg::OP_FLUSH: begin
        rd_ptr_next = '0;
        wr_ptr_next = '0;
        occ_next    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      occ    <= '0;
      phase  <= '0;
      tally  <= '0;
    end else if (commit) begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      occ    <= occ_next;
      phase  <= phase_next;
      tally  <= tally_next;
    end
  end

  // sample RAM: read issued in the cycle after capture, data held until commit
  always_ff @(posedge clk) begin
    if (mem_we)           mem[wr_ptr] <= wr_value;
    if (state == ST_MUL)  rd_data     <= mem[rd_ptr];
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst)          out_valid <= 1'b0;
    else if (commit)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      sample_out    <= res_sample;
      accepted      <= res_acc;
      underrun      <= res_under;
      fill_level    <= afv_pkg::FILL_W'(occ_next);
      written_total <= tally_next;
    end
  end

endmodule

/* src/afv_scale.sv */
// Two-stage volume scaler: signed multiply, then reciprocal divide by 100,
// truncation toward zero and int16 saturation.
module afv_scale (
  input  logic                            clk,
  input  afv_pkg::scale_req_t             req,
  output logic [afv_pkg::SAMPLE_W-1:0]    scaled
);

  localparam int QP_W = afv_pkg::MAG_W + afv_pkg::RECIP_W;

  logic signed [afv_pkg::PROD_W-1:0] s_ext;
  logic signed [afv_pkg::PROD_W-1:0] v_ext;
  logic signed [afv_pkg::PROD_W-1:0] prod;
  logic        [afv_pkg::PROD_W-1:0] abs_prod;
  logic        [afv_pkg::MAG_W-1:0]  mag;
  logic                              neg;
  logic        [QP_W-1:0]            qprod;
  logic        [afv_pkg::SAMPLE_W-1:0] quot;
  logic                              quot_neg;

  always_comb begin
    s_ext    = {{(afv_pkg::PROD_W - afv_pkg::SAMPLE_W){req.sample[afv_pkg::SAMPLE_W-1]}},
                req.sample};
    v_ext    = {{(afv_pkg::PROD_W - afv_pkg::VOL_W){1'b0}}, req.vol};
    prod     = s_ext * v_ext;
    abs_prod = prod[afv_pkg::PROD_W-1] ? (~prod + 1'b1) : prod;
  end

  // stage 1: sign and magnitude of the product
  always_ff @(posedge clk) begin
    neg <= prod[afv_pkg::PROD_W-1];
    mag <= abs_prod[afv_pkg::MAG_W-1:0];
  end

  assign qprod = {{afv_pkg::RECIP_W{1'b0}}, mag} * {{afv_pkg::MAG_W{1'b0}}, afv_pkg::DIV_RECIP};

  // stage 2: quotient magnitude
  always_ff @(posedge clk) begin
    quot_neg <= neg;
    quot     <= qprod[afv_pkg::DIV_SHIFT +: afv_pkg::SAMPLE_W];
  end

  always_comb begin
    if (!quot_neg) begin
      scaled = (quot > 16'h7FFF) ? 16'h7FFF : quot;
    end else begin
      scaled = (quot > 16'h8000) ? 16'h8000 : (~quot + 16'd1);
    end
  end

endmodule

/* src/afv_checker.sv */
module afv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [afv_pkg::SAMPLE_W-1:0]   sample_out,
  input logic                           accepted,
  input logic                           underrun,
  input logic [afv_pkg::FILL_W-1:0]     fill_level
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(fill_level))
    else $error("result changed while stalled");

  // a read is either served or flagged, never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && underrun))
    else $error("accepted and underrun both set");

  // silence on underrun
  a_silence: assert property (@(posedge clk) disable iff (rst)
    out_valid && underrun |-> sample_out == '0)
    else $error("underrun with non-zero sample");

  // level never passes the depth
  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= afv_pkg::FILL_W'(afv_pkg::FIFO_DEPTH))
    else $error("fill level beyond depth");

endmodule

bind audio_playback_fifo_with_volume afv_checker u_afv_checker (.*);

/* tb/audio_playback_fifo_with_volume_tb.sv */
`timescale 1ns / 100ps

module audio_playback_fifo_with_volume_tb;
  import afv_pkg::*;

  // Operation code 3 has no meaning in the block; it must leave the state alone
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int          LONG_HOLD   = 80;        // receiver stall that backs up the input
  localparam int          END_PAUSE   = 20;        // pause after the last result, before the verdict
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One result transfer, field by field
  typedef struct packed {
    logic [SAMPLE_W-1:0] data;
    logic                acc;
    logic                urun;
    logic [FILL_W-1:0]   fill;
    logic [TALLY_W-1:0]  total;
  } result_t;

  // Directed plan row: either a register write or an item, the latter optionally with
  // its result written out by hand
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [OP_W-1:0]       op;
    logic [SAMPLE_W-1:0]   smp;
    logic                  last;
    bit                    pinned;
    result_t               res;
  } row_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Block inputs, all known from time zero
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_FORMAT;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic [OP_W-1:0]       operation     = OP_WRITE;
  logic [SAMPLE_W-1:0]   sample_in     = '0;
  logic                  last_of_block = 1'b0;
  logic                  out_ready     = 1'b0;

  // Block outputs
  logic                  in_ready;
  logic                  out_valid;
  logic [SAMPLE_W-1:0]   sample_out;
  logic                  accepted;
  logic                  underrun;
  logic [FILL_W-1:0]     fill_level;
  logic [TALLY_W-1:0]    written_total;

  // Hand-written result travelling alongside the payload, so it lines up with the
  // item at its transfer edge
  logic    pin_flag  = 1'b0;
  result_t pin_value = '0;

  // Shadow of the block: configuration, FIFO contents and counters
  logic                  sh_format;
  logic [CHAN_W-1:0]     sh_channels;
  logic [VOL_W-1:0]      sh_vol_left;
  logic [VOL_W-1:0]      sh_vol_right;
  logic                  sh_paused;
  logic                  sh_active;
  logic [SAMPLE_W-1:0]   sample_img [FIFO_DEPTH];
  int                    rd_idx;
  int                    wr_idx;
  int                    held;
  int                    chan_phase;
  logic [TALLY_W-1:0]    stored_count;

  result_t     due_results [$];   // results owed by the block, oldest first
  int          errors = 0;
  bit          idle_en = 1'b1;    // random idling on both sides
  bit          long_hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  audio_playback_fifo_with_volume u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .sample_in    (sample_in),
    .last_of_block(last_of_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .accepted     (accepted),
    .underrun     (underrun),
    .fill_level   (fill_level),
    .written_total(written_total)
  );

  // Percent gain: product truncated toward zero, then clamped to int16
  function automatic logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] raw,
                                                     logic [VOL_W-1:0] gain);
    int s;
    int g;
    int prod;
    s = $signed(raw);
    g = gain;
    prod = (s * g) / 100;
    if (prod > 32767) prod = 32767;
    if (prod < -32768) prod = -32768;
    return prod[SAMPLE_W-1:0];
  endfunction

  function automatic void clear_shadow();
    sh_format    = 1'b1;
    sh_channels  = CHAN_RESET;
    sh_vol_left  = VOL_UNITY;
    sh_vol_right = VOL_UNITY;
    sh_paused    = 1'b0;
    sh_active    = 1'b0;
    rd_idx       = 0;
    wr_idx       = 0;
    held         = 0;
    chan_phase   = 0;
    stored_count = '0;
  endfunction

  function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FORMAT:    sh_format    = val[0];
      REG_CHANNELS:  sh_channels  = val[CHAN_W-1:0];
      REG_VOL_LEFT:  sh_vol_left  = val[VOL_W-1:0];
      REG_VOL_RIGHT: sh_vol_right = val[VOL_W-1:0];
      REG_PAUSED:    sh_paused    = val[0];
      REG_ACTIVE:    sh_active    = val[0];
      default: ;
    endcase
  endfunction

  // Advances the shadow by one item and returns the result it owes
  function automatic result_t playback_step(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                                            logic last);
    result_t r;
    int nch;
    int ph;
    logic [SAMPLE_W-1:0] val;
    r = '0;
    case (op)
      OP_WRITE: begin
        nch = sh_channels;
        if (nch == 0) nch = 1;
        if (nch > CHAN_MAX) nch = CHAN_MAX;
        ph = (chan_phase >= nch) ? 0 : chan_phase;
        if (sh_format) begin
          val = smp;
          if (sh_vol_left != VOL_UNITY || sh_vol_right != VOL_UNITY) begin
            if (ph == 0) val = apply_gain(smp, sh_vol_left);
            else if (ph == 1 && nch > 1) val = apply_gain(smp, sh_vol_right);
          end
        end else begin
          val = {8'h00, smp[7:0]};
        end
        if (sh_active && held < FIFO_DEPTH) begin
          sample_img[wr_idx] = val;
          wr_idx = (wr_idx + 1) % FIFO_DEPTH;
          held++;
          stored_count++;
          r.acc = 1'b1;
        end
        // phase moves on whether or not the sample went in
        if (last) chan_phase = 0;
        else chan_phase = (ph + 1 >= nch) ? 0 : ph + 1;
      end
      OP_READ: begin
        if (sh_paused || !sh_active || held == 0) begin
          r.urun = 1'b1;
        end else begin
          r.data = sample_img[rd_idx];
          rd_idx = (rd_idx + 1) % FIFO_DEPTH;
          held--;
          r.acc = 1'b1;
        end
      end
      OP_FLUSH: begin
        rd_idx = 0;
        wr_idx = 0;
        held   = 0;
      end
      default: ;
    endcase
    r.fill  = FILL_W'(held);
    r.total = stored_count;
    return r;
  endfunction

  task automatic compare_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  // Edge monitor: register writes and item transfers feed the shadow, result
  // transfers are checked against the oldest owed result. Everything here reads
  // pre-edge values, as the flops do.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      clear_shadow();
      due_results.delete();
    end else begin
      if (cfg_we) shadow_reg_write(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        got = '{sample_out, accepted, underrun, fill_level, written_total};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing owed, expected none, actual 0x%0h",
                   $time, got);
        end else begin
          want = due_results.pop_front();
          compare_field("sample_out", want.data, got.data);
          compare_field("accepted", want.acc, got.acc);
          compare_field("underrun", want.urun, got.urun);
          compare_field("fill_level", want.fill, got.fill);
          compare_field("written_total", want.total, got.total);
        end
      end
      if (in_valid && in_ready) begin
        want = playback_step(operation, sample_in, last_of_block);
        due_results.push_back(pin_flag ? pin_value : want);
      end
    end
  end

  // Receiver: ready most of the time, random stall bursts, and one long hold-off
  // on request so the block backs up and drops in_ready
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("audio_playback_fifo_with_volume regression: fail");
    $finish;
  end

  // Offers one item and returns at the edge of its transfer; valid stays up into the
  // next item unless an idle burst is drawn
  task automatic offer(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp, logic last,
                       bit pinned, result_t res);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    sample_in     <= smp;
    last_of_block <= last;
    pin_flag      <= pinned;
    pin_value     <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every owed result has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic row_t item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp, logic last);
    row_t r;
    r = '{default: '0};
    r.op   = op;
    r.smp  = smp;
    r.last = last;
    return r;
  endfunction

  function automatic row_t pinned_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                                       logic last, result_t res);
    row_t r;
    r = item(op, smp, last);
    r.pinned = 1'b1;
    r.res    = res;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return VOL_UNITY;
      2:       return 7'd127;
      default: return CFG_DATA_W'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic random_burst(int n);
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] s;
    int                  pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 52) op = OP_WRITE;
      else if (pick < 94) op = OP_READ;
      else if (pick < 98) op = OP_FLUSH;
      else op = OP_SPARE;
      case ($urandom_range(0, 7))
        0:       s = 16'h7fff;
        1:       s = 16'h8000;
        2:       s = 16'hffff;
        3:       s = 16'h0000;
        4:       s = SAMPLE_W'($urandom_range(0, 600)) - 16'd300;
        default: s = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      offer(op, s, $urandom_range(0, 5) == 0, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    row_t plan [$];
    bit   unity;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan. Reset leaves 16-bit, two channels, unity gain, not paused and
    // inactive; results are written out by hand while they are obvious.
    plan.push_back(pinned_item(OP_WRITE, 16'h1234, 1'b0, '{16'h0, 1'b0, 1'b0, 13'd0, 32'd0}));
    plan.push_back(pinned_item(OP_READ, 16'h0, 1'b0, '{16'h0, 1'b0, 1'b1, 13'd0, 32'd0}));
    plan.push_back(reg_row(REG_ACTIVE, 7'd1));
    plan.push_back(pinned_item(OP_WRITE, 16'h7fff, 1'b1, '{16'h0, 1'b1, 1'b0, 13'd1, 32'd1}));
    plan.push_back(pinned_item(OP_WRITE, 16'h8000, 1'b0, '{16'h0, 1'b1, 1'b0, 13'd2, 32'd2}));
    plan.push_back(pinned_item(OP_READ, 16'h0, 1'b0, '{16'h7fff, 1'b1, 1'b0, 13'd1, 32'd2}));
    plan.push_back(pinned_item(OP_READ, 16'h0, 1'b0, '{16'h8000, 1'b1, 1'b0, 13'd0, 32'd2}));
    plan.push_back(pinned_item(OP_READ, 16'hffff, 1'b1, '{16'h0, 1'b0, 1'b1, 13'd0, 32'd2}));
    // gain extremes: silence on the left, over-unity and clamping on the right
    plan.push_back(reg_row(REG_VOL_LEFT, 7'd0));
    plan.push_back(reg_row(REG_VOL_RIGHT, 7'd127));
    plan.push_back(item(OP_WRITE, 16'h7fff, 1'b0));
    plan.push_back(item(OP_WRITE, 16'h8000, 1'b0));
    plan.push_back(item(OP_WRITE, 16'h8000, 1'b1));
    // negative product must round toward zero
    plan.push_back(reg_row(REG_VOL_LEFT, 7'd1));
    plan.push_back(item(OP_WRITE, 16'hff39, 1'b0));
    // zero channels behaves as mono; a stale phase wraps
    plan.push_back(reg_row(REG_CHANNELS, 7'd0));
    plan.push_back(item(OP_WRITE, 16'h00c7, 1'b0));
    // oversized count behaves as eight; channel 2 onwards never scaled
    plan.push_back(reg_row(REG_CHANNELS, 7'd15));
    plan.push_back(item(OP_WRITE, 16'h1234, 1'b0));
    plan.push_back(item(OP_WRITE, 16'h4000, 1'b0));
    plan.push_back(item(OP_WRITE, 16'h4000, 1'b0));
    // 8-bit format keeps the low byte only
    plan.push_back(reg_row(REG_FORMAT, 7'd0));
    plan.push_back(item(OP_WRITE, 16'habcd, 1'b1));
    plan.push_back(reg_row(REG_PAUSED, 7'd1));
    plan.push_back(item(OP_READ, 16'h0, 1'b0));
    plan.push_back(reg_row(REG_PAUSED, 7'd0));
    plan.push_back(item(OP_READ, 16'h0, 1'b0));
    plan.push_back(item(OP_READ, 16'h0, 1'b0));
    plan.push_back(item(OP_READ, 16'h0, 1'b0));
    plan.push_back(item(OP_FLUSH, 16'hffff, 1'b1));
    plan.push_back(item(OP_SPARE, 16'h5a5a, 1'b0));
    plan.push_back(item(OP_READ, 16'h0, 1'b0));
    // unity gain on both sides skips scaling; inactive drops writes
    plan.push_back(reg_row(REG_FORMAT, 7'd1));
    plan.push_back(reg_row(REG_VOL_LEFT, VOL_UNITY));
    plan.push_back(reg_row(REG_VOL_RIGHT, VOL_UNITY));
    plan.push_back(reg_row(REG_ACTIVE, 7'd0));
    plan.push_back(item(OP_WRITE, 16'h8001, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        offer(plan[i].op, plan[i].smp, plan[i].last, plan[i].pinned, plan[i].res);
      end
    end
    drain();

    // A short run of writes with scaling on, then read back past empty
    set_reg(REG_FORMAT, 7'd1);
    set_reg(REG_CHANNELS, 7'd2);
    set_reg(REG_VOL_LEFT, 7'd50);
    set_reg(REG_VOL_RIGHT, VOL_UNITY);
    set_reg(REG_PAUSED, 7'd0);
    set_reg(REG_ACTIVE, 7'd1);
    offer(OP_FLUSH, 16'h0, 1'b0, 1'b0, '0);
    repeat (16)
      offer(OP_WRITE, SAMPLE_W'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0,
            1'b0, '0);
    repeat (18) offer(OP_READ, 16'h0, 1'b0, 1'b0, '0);
    drain();

    // Random phases, each under fresh settings; the last ones run without idling
    for (int ph = 0; ph < 10; ph++) begin
      if (ph >= 8) idle_en = 1'b0;
      unity = ($urandom_range(0, 4) == 0);
      set_reg(REG_FORMAT, CFG_DATA_W'($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 4) == 0) set_reg(REG_CHANNELS, CFG_DATA_W'($urandom_range(0, 15)));
      else set_reg(REG_CHANNELS, CFG_DATA_W'($urandom_range(1, 8)));
      set_reg(REG_VOL_LEFT, unity ? VOL_UNITY : pick_gain());
      set_reg(REG_VOL_RIGHT, unity ? VOL_UNITY : pick_gain());
      set_reg(REG_PAUSED, CFG_DATA_W'($urandom_range(0, 7) == 0));
      set_reg(REG_ACTIVE, CFG_DATA_W'($urandom_range(0, 7) != 0));
      // one phase starts with a long receiver stall while items keep coming
      if (ph == 3) long_hold_pending = 1'b1;
      random_burst(50);
      drain();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (errors == 0) $display("audio_playback_fifo_with_volume regression: pass");
    else $display("audio_playback_fifo_with_volume regression: fail");
    $finish;
  end

endmodule
